// File: src/otr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otr_pkg
// Shared types, codes and sizes of the outstanding request tracker.
// ----------------------------------------------------------------------------
package otr_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] CMD_BEGIN    = 2'd0;
    localparam logic [1:0] CMD_COMPLETE = 2'd1;
    localparam logic [1:0] CMD_FIND     = 2'd2;
    localparam logic [1:0] CMD_READ     = 2'd3;

    localparam logic [2:0] RC_OK          = 3'd0;
    localparam logic [2:0] RC_INVALID_ARG = 3'd1;
    localparam logic [2:0] RC_EXISTS      = 3'd2;
    localparam logic [2:0] RC_CAPACITY    = 3'd3;
    localparam logic [2:0] RC_NOT_FOUND   = 3'd4;
    localparam logic [2:0] RC_BAD_STATE   = 3'd5;

    localparam logic [1:0] ST_PENDING   = 2'd0;
    localparam logic [1:0] ST_COMPLETED = 2'd1;
    localparam logic [1:0] ST_FAILED    = 2'd2;

    localparam logic [2:0] STATUS_OK   = 3'd0;
    localparam logic [2:0] STATUS_BUSY = 3'd6;

    typedef struct packed {
        logic [63:0] id;
        logic [1:0]  state;
        logic [2:0]  status;
        logic [63:0] revision;
        logic [63:0] done_time;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } table_wr_t;

endpackage

// File: src/otr_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otr_table
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module otr_table
    import otr_pkg::*;
(
    input  logic             clk,
    input  table_wr_t        wr,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/outstanding_request_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// outstanding_request_tracker
// Append-only table of outstanding requests with begin, complete, find by id
// and read by index; ids are searched one entry per cycle through the table.
//
//   channel  handshake            payload
//   request  req_valid/req_stall  cmd, req_id, method_present,
//                                 completion_status, completed_time, entry_index
//   response rsp_valid/rsp_stall  result_code, rec_*, entry_count, pending_count
//
// Read fetches its entry through the registered table read port; begin, complete
// and find scan the entries below entry_count through that single read port, one entry
// per cycle. Requests that fail their argument check, and reads past the end,
// skip the table and go to delivery.
// Reset clears the counts and sets the revision to 1; table contents are not
// cleared, and only positions below entry_count are ever read.
// req_stall is high from accepting a request until its result is loaded into
// the output register; a result held by rsp_stall does not block the next
// request, only the delivery of the one after it.
// ----------------------------------------------------------------------------
module outstanding_request_tracker
    import otr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         cmd,
    input  logic signed [63:0] req_id,
    input  logic               method_present,
    input  logic [2:0]         completion_status,
    input  logic [63:0]        completed_time,
    input  logic [5:0]         entry_index,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [2:0]         result_code,
    output logic signed [63:0] rec_id,
    output logic [1:0]         rec_state,
    output logic [2:0]         rec_status,
    output logic [63:0]        rec_revision,
    output logic [63:0]        rec_completed_at,
    output logic [6:0]         entry_count,
    output logic [6:0]         pending_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_RD_WAIT,
        S_RESOLVE,
        S_DELIVER
    } state_t;

    state_t           state_reg,      state_next;
    logic [1:0]       req_cmd_reg,    req_cmd_next;
    logic [63:0]      req_id_reg,     req_id_next;
    logic             req_method_reg, req_method_next;
    logic [2:0]       req_status_reg, req_status_next;
    logic [63:0]      req_time_reg,   req_time_next;
    logic [5:0]       req_index_reg,  req_index_next;
    logic [CNT_W-1:0] scan_addr_reg,  scan_addr_next;
    logic             cmp_pend_reg,   cmp_pend_next;
    logic [IDX_W-1:0] cmp_addr_reg,   cmp_addr_next;
    logic             hit_reg,        hit_next;
    logic [IDX_W-1:0] hit_addr_reg,   hit_addr_next;
    logic [2:0]       res_code_reg,   res_code_next;
    entry_t           res_entry_reg,  res_entry_next;
    logic [CNT_W-1:0] filled_reg,     filled_next;
    logic [CNT_W-1:0] open_reg,       open_next;
    logic [63:0]      rev_reg,        rev_next;
    logic             rsp_valid_reg,  rsp_valid_next;
    logic [2:0]       rsp_code_reg,   rsp_code_next;
    entry_t           rsp_entry_reg,  rsp_entry_next;
    logic [CNT_W-1:0] rsp_filled_reg, rsp_filled_next;
    logic [CNT_W-1:0] rsp_open_reg,   rsp_open_next;

    table_wr_t        tbl_wr;
    logic [IDX_W-1:0] tbl_rd_addr;
    entry_t           tbl_rd_data;
    logic             id_pos;
    logic             id_match;
    logic [63:0]      rev_inc;

    otr_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    assign id_pos      = (req_id_reg != 64'd0) && !req_id_reg[63];
    assign id_match    = cmp_pend_reg && (tbl_rd_data.id == req_id_reg);
    assign rev_inc     = rev_reg + 64'd1;
    assign tbl_rd_addr = (state_reg == S_SCAN) ? scan_addr_reg[IDX_W-1:0]
                                               : IDX_W'(req_index_reg);
    assign req_stall   = (state_reg != S_IDLE);

    always_comb
    begin
        entry_t new_entry;
        new_entry       = res_entry_reg;
        state_next      = state_reg;
        req_cmd_next    = req_cmd_reg;
        req_id_next     = req_id_reg;
        req_method_next = req_method_reg;
        req_status_next = req_status_reg;
        req_time_next   = req_time_reg;
        req_index_next  = req_index_reg;
        scan_addr_next  = scan_addr_reg;
        cmp_pend_next   = cmp_pend_reg;
        cmp_addr_next   = cmp_addr_reg;
        hit_next        = hit_reg;
        hit_addr_next   = hit_addr_reg;
        res_code_next   = res_code_reg;
        res_entry_next  = res_entry_reg;
        filled_next     = filled_reg;
        open_next       = open_reg;
        rev_next        = rev_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_code_next   = rsp_code_reg;
        rsp_entry_next  = rsp_entry_reg;
        rsp_filled_next = rsp_filled_reg;
        rsp_open_next   = rsp_open_reg;
        tbl_wr          = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_cmd_next    = cmd;
                    req_id_next     = req_id;
                    req_method_next = method_present;
                    req_status_next = completion_status;
                    req_time_next   = completed_time;
                    req_index_next  = entry_index;
                    state_next      = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_entry_next = '0;
                res_code_next  = RC_OK;
                scan_addr_next = '0;
                cmp_pend_next  = 1'b0;
                hit_next       = 1'b0;
                state_next     = S_SCAN;
                unique case (req_cmd_reg)
                    CMD_BEGIN:
                    begin
                        if (!id_pos || !req_method_reg)
                        begin
                            res_code_next = RC_INVALID_ARG;
                            state_next    = S_DELIVER;
                        end
                    end
                    CMD_COMPLETE:
                    begin
                        if (!id_pos)
                        begin
                            res_code_next = RC_INVALID_ARG;
                            state_next    = S_DELIVER;
                        end
                    end
                    CMD_FIND:
                    begin
                        state_next = S_SCAN;
                    end
                    CMD_READ:
                    begin
                        if (CNT_W'(req_index_reg) >= filled_reg)
                        begin
                            res_code_next = RC_NOT_FOUND;
                            state_next    = S_DELIVER;
                        end
                        else
                        begin
                            state_next = S_RD_WAIT;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                priority if (id_match)
                begin
                    hit_next       = 1'b1;
                    hit_addr_next  = cmp_addr_reg;
                    res_entry_next = tbl_rd_data;
                    state_next     = S_RESOLVE;
                end
                else if (scan_addr_reg < filled_reg)
                begin
                    cmp_pend_next  = 1'b1;
                    cmp_addr_next  = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end
                else if (cmp_pend_reg)
                begin
                    cmp_pend_next = 1'b0;
                end
                else
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RD_WAIT:
            begin
                res_entry_next = tbl_rd_data;
                res_code_next  = RC_OK;
                state_next     = S_DELIVER;
            end
            S_RESOLVE:
            begin
                state_next = S_DELIVER;
                unique case (req_cmd_reg)
                    CMD_BEGIN:
                    begin
                        priority if (hit_reg)
                        begin
                            res_code_next  = RC_EXISTS;
                            res_entry_next = '0;
                        end
                        else if (filled_reg >= CNT_W'(TABLE_DEPTH))
                        begin
                            res_code_next  = RC_CAPACITY;
                            res_entry_next = '0;
                        end
                        else
                        begin
                            new_entry.id        = req_id_reg;
                            new_entry.state     = ST_PENDING;
                            new_entry.status    = STATUS_BUSY;
                            new_entry.revision  = rev_inc;
                            new_entry.done_time = req_time_reg;
                            tbl_wr.en       = 1'b1;
                            tbl_wr.addr     = filled_reg[IDX_W-1:0];
                            tbl_wr.data     = new_entry;
                            filled_next     = filled_reg + CNT_W'(1);
                            open_next       = open_reg + CNT_W'(1);
                            rev_next        = rev_inc;
                            res_entry_next  = new_entry;
                            res_code_next   = RC_OK;
                        end
                    end
                    CMD_COMPLETE:
                    begin
                        priority if (!hit_reg)
                        begin
                            res_code_next  = RC_NOT_FOUND;
                            res_entry_next = '0;
                        end
                        else if (res_entry_reg.state != ST_PENDING)
                        begin
                            res_code_next  = RC_BAD_STATE;
                            res_entry_next = '0;
                        end
                        else
                        begin
                            new_entry.done_time = req_time_reg;
                            new_entry.status    = req_status_reg;
                            new_entry.state     = (req_status_reg == STATUS_OK)
                                                  ? ST_COMPLETED : ST_FAILED;
                            new_entry.revision  = rev_inc;
                            tbl_wr.en      = 1'b1;
                            tbl_wr.addr    = hit_addr_reg;
                            tbl_wr.data    = new_entry;
                            if (open_reg != '0)
                            begin
                                open_next = open_reg - CNT_W'(1);
                            end
                            rev_next       = rev_inc;
                            res_entry_next = new_entry;
                            res_code_next  = RC_OK;
                        end
                    end
                    CMD_FIND:
                    begin
                        if (!hit_reg)
                        begin
                            res_code_next  = RC_NOT_FOUND;
                            res_entry_next = '0;
                        end
                        else
                        begin
                            res_code_next = RC_OK;
                        end
                    end
                    CMD_READ:
                    begin
                        res_code_next  = RC_NOT_FOUND;
                        res_entry_next = '0;
                    end
                endcase
            end
            S_DELIVER:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_code_next   = res_code_reg;
                    rsp_entry_next  = res_entry_reg;
                    rsp_filled_next = filled_reg;
                    rsp_open_next   = open_reg;
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_cmd_reg    <= '0;
            req_id_reg     <= '0;
            req_method_reg <= 1'b0;
            req_status_reg <= '0;
            req_time_reg   <= '0;
            req_index_reg  <= '0;
            scan_addr_reg  <= '0;
            cmp_pend_reg   <= 1'b0;
            cmp_addr_reg   <= '0;
            hit_reg        <= 1'b0;
            hit_addr_reg   <= '0;
            res_code_reg   <= RC_OK;
            res_entry_reg  <= '0;
            filled_reg     <= '0;
            open_reg       <= '0;
            rev_reg        <= 64'd1;
            rsp_valid_reg  <= 1'b0;
            rsp_code_reg   <= RC_OK;
            rsp_entry_reg  <= '0;
            rsp_filled_reg <= '0;
            rsp_open_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            req_cmd_reg    <= req_cmd_next;
            req_id_reg     <= req_id_next;
            req_method_reg <= req_method_next;
            req_status_reg <= req_status_next;
            req_time_reg   <= req_time_next;
            req_index_reg  <= req_index_next;
            scan_addr_reg  <= scan_addr_next;
            cmp_pend_reg   <= cmp_pend_next;
            cmp_addr_reg   <= cmp_addr_next;
            hit_reg        <= hit_next;
            hit_addr_reg   <= hit_addr_next;
            res_code_reg   <= res_code_next;
            res_entry_reg  <= res_entry_next;
            filled_reg     <= filled_next;
            open_reg       <= open_next;
            rev_reg        <= rev_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_code_reg   <= rsp_code_next;
            rsp_entry_reg  <= rsp_entry_next;
            rsp_filled_reg <= rsp_filled_next;
            rsp_open_reg   <= rsp_open_next;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign result_code      = rsp_code_reg;
    assign rec_id           = rsp_entry_reg.id;
    assign rec_state        = rsp_entry_reg.state;
    assign rec_status       = rsp_entry_reg.status;
    assign rec_revision     = rsp_entry_reg.revision;
    assign rec_completed_at = rsp_entry_reg.done_time;
    assign entry_count      = 7'(rsp_filled_reg);
    assign pending_count    = 7'(rsp_open_reg);

    a_open_within_filled: assert property (
        @(posedge clk) disable iff (!rst_n)
        open_reg <= filled_reg
    ) else $error("pending count above entry count");

    a_filled_within_depth: assert property (
        @(posedge clk) disable iff (!rst_n)
        filled_reg <= CNT_W'(TABLE_DEPTH)
    ) else $error("entry count above table depth");

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall
    ) else $error("request taken while previous one still in work");

    a_failed_result_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && result_code != RC_OK |-> rec_revision == 64'd0 && rec_id == 64'sd0
    ) else $error("failed result carries entry data");

    a_revision_tracks_change: assert property (
        @(posedge clk) disable iff (!rst_n)
        rev_reg != $past(rev_reg) |-> $past(tbl_wr.en)
    ) else $error("revision moved without a table write");

endmodule
